FILE: design/owsrch_pkg.sv
`default_nettype none

package owsrch_pkg;

  localparam int unsigned ROM_CODE_W = 64;
  localparam int unsigned CRC_W      = 8;
  localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 4;

  typedef enum logic {
    REQ_BEGIN = 1'b0,
    REQ_BIT   = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_OK      = 3'd1,
    ST_CRCBAD  = 3'd2,
    ST_NOPRES  = 3'd3,
    ST_BOTH1   = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef struct packed {
    req_t req_type;
    logic new_enum;
    logic presence;
    logic id_bit;
    logic cmp_bit;
  } item_t;

  typedef struct packed {
    logic                  dir_valid;
    logic                  dir_bit;
    status_t               status;
    logic [ROM_CODE_W-1:0] rom_code;
    logic                  last_device;
  } result_t;

endpackage

`default_nettype wire

FILE: design/owsrch_step.sv
`default_nettype none

module owsrch_step #(
  parameter int unsigned ROM_BITS = 64,
  parameter int unsigned POS_W    = $clog2(ROM_BITS + 1),
  parameter int unsigned IDX_W    = $clog2(ROM_BITS)
) (
  input  wire owsrch_pkg::item_t         item,
  input  wire logic                      pass_active,
  input  wire logic [POS_W-1:0]          bit_position,
  input  wire logic [ROM_BITS-1:0]       path_bits,
  input  wire logic [POS_W-1:0]          last_disc,
  input  wire logic [POS_W-1:0]          pass_disc,
  input  wire logic [owsrch_pkg::CRC_W-1:0] crc,
  input  wire logic                      enum_done,
  output logic                           pass_active_nxt,
  output logic [POS_W-1:0]               bit_position_nxt,
  output logic [ROM_BITS-1:0]            path_bits_nxt,
  output logic [POS_W-1:0]               last_disc_nxt,
  output logic [POS_W-1:0]               pass_disc_nxt,
  output logic [owsrch_pkg::CRC_W-1:0]   crc_nxt,
  output logic                           enum_done_nxt,
  output owsrch_pkg::result_t            result
);
  import owsrch_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(ROM_BITS);

  logic [IDX_W-1:0] idx;
  logic [POS_W-1:0] pos;
  logic             dir;
  logic             fb;

  assign idx = bit_position[IDX_W-1:0];
  assign pos = bit_position + POS_W'(1);

  always_comb begin
    pass_active_nxt  = pass_active;
    bit_position_nxt = bit_position;
    path_bits_nxt    = path_bits;
    last_disc_nxt    = last_disc;
    pass_disc_nxt    = pass_disc;
    crc_nxt          = crc;
    enum_done_nxt    = enum_done;
    result.dir_valid = 1'b0;
    result.dir_bit   = 1'b0;
    result.status    = ST_IGNORED;
    result.rom_code  = '0;
    dir              = item.id_bit;
    fb               = 1'b0;

    if (item.req_type == REQ_BEGIN) begin
      if (item.new_enum) begin
        last_disc_nxt = '0;
        enum_done_nxt = 1'b0;
      end
      if (enum_done_nxt) begin
        result.status = ST_IGNORED;
      end else if (!item.presence) begin
        pass_active_nxt = 1'b0;
        result.status   = ST_NOPRES;
      end else begin
        pass_active_nxt  = 1'b1;
        bit_position_nxt = '0;
        pass_disc_nxt    = '0;
        crc_nxt          = '0;
        result.status    = ST_BUSY;
      end
    end else if (pass_active) begin
      if (item.id_bit && item.cmp_bit) begin
        pass_active_nxt = 1'b0;
        result.status   = ST_BOTH1;
      end else begin
        if (!item.id_bit && !item.cmp_bit) begin
          if (pos == last_disc) begin
            dir = 1'b1;
          end else if (pos > last_disc) begin
            dir           = 1'b0;
            pass_disc_nxt = pos;
          end else begin
            dir = path_bits[idx];
            if (!dir) begin
              pass_disc_nxt = pos;
            end
          end
        end
        path_bits_nxt[idx] = dir;
        fb                 = crc[0] ^ dir;
        crc_nxt            = (crc >> 1) ^ (fb ? CRC_POLY : '0);
        result.dir_valid   = 1'b1;
        result.dir_bit     = dir;
        bit_position_nxt   = pos;
        result.status      = ST_BUSY;
        if (pos >= LAST_POS) begin
          pass_active_nxt = 1'b0;
          last_disc_nxt   = pass_disc_nxt;
          if (pass_disc_nxt == '0) begin
            enum_done_nxt = 1'b1;
          end
          result.rom_code = ROM_CODE_W'(path_bits_nxt);
          result.status   = (crc_nxt == '0) ? ST_OK : ST_CRCBAD;
        end
      end
    end

    result.last_device = enum_done_nxt;
  end

endmodule

`default_nettype wire

FILE: design/onewire_rom_search_crc8.sv
// 1-Wire Search ROM master with CRC-8 check, one result item per input item.
// Items pass an input register, then a result register; both hold under output back-pressure.
// One item per cycle unless the output stalls; per-bit decision and CRC step sit between them.
// Reset (rst_n low, synchronous) clears the search state and both pipeline valids.
`default_nettype none

module onewire_rom_search_crc8 #(
  parameter int unsigned ROM_BITS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [owsrch_pkg::IN_TDATA_W-1:0]   in_tdata,  // new_enum, presence, id_bit, cmp_bit
  input  wire logic                                in_tuser,  // req_type
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [owsrch_pkg::OUT_TDATA_W-1:0]       out_tdata, // dir_bit, rom_code, last_device
  output logic [owsrch_pkg::OUT_TUSER_W-1:0]       out_tuser  // dir_valid, status[2:0]
);
  import owsrch_pkg::*;

  localparam int unsigned POS_W = $clog2(ROM_BITS + 1);
  localparam int unsigned IDX_W = $clog2(ROM_BITS);

  logic          s1_valid_r;
  item_t         s1_item_r;
  logic          out_valid_r;
  result_t       out_res_r;
  logic          advance;
  logic          fire;
  result_t       res_nxt;

  logic                pass_active_r, pass_active_nxt;
  logic [POS_W-1:0]    bit_position_r, bit_position_nxt;
  logic [ROM_BITS-1:0] path_bits_r, path_bits_nxt;
  logic [POS_W-1:0]    last_disc_r, last_disc_nxt;
  logic [POS_W-1:0]    pass_disc_r, pass_disc_nxt;
  logic [CRC_W-1:0]    crc_r, crc_nxt;
  logic                enum_done_r, enum_done_nxt;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.req_type <= req_t'(in_tuser);
      s1_item_r.new_enum <= in_tdata[0];
      s1_item_r.presence <= in_tdata[1];
      s1_item_r.id_bit   <= in_tdata[2];
      s1_item_r.cmp_bit  <= in_tdata[3];
    end
  end

  owsrch_step #(
    .ROM_BITS (ROM_BITS),
    .POS_W    (POS_W),
    .IDX_W    (IDX_W)
  ) u_step (
    .item             (s1_item_r),
    .pass_active      (pass_active_r),
    .bit_position     (bit_position_r),
    .path_bits        (path_bits_r),
    .last_disc        (last_disc_r),
    .pass_disc        (pass_disc_r),
    .crc              (crc_r),
    .enum_done        (enum_done_r),
    .pass_active_nxt  (pass_active_nxt),
    .bit_position_nxt (bit_position_nxt),
    .path_bits_nxt    (path_bits_nxt),
    .last_disc_nxt    (last_disc_nxt),
    .pass_disc_nxt    (pass_disc_nxt),
    .crc_nxt          (crc_nxt),
    .enum_done_nxt    (enum_done_nxt),
    .result           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_active_r  <= 1'b0;
      bit_position_r <= '0;
      path_bits_r    <= '0;
      last_disc_r    <= '0;
      pass_disc_r    <= '0;
      crc_r          <= '0;
      enum_done_r    <= 1'b0;
    end else if (fire) begin
      pass_active_r  <= pass_active_nxt;
      bit_position_r <= bit_position_nxt;
      path_bits_r    <= path_bits_nxt;
      last_disc_r    <= last_disc_nxt;
      pass_disc_r    <= pass_disc_nxt;
      crc_r          <= crc_nxt;
      enum_done_r    <= enum_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ROM_CODE_W - 2){1'b0}}, out_res_r.last_device,
                       out_res_r.rom_code, out_res_r.dir_bit};
  assign out_tuser  = {out_res_r.status, out_res_r.dir_valid};

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pass_active_r |-> (bit_position_r < POS_W'(ROM_BITS)))
    else $error("bit position past ROM length during active pass");

  a_end_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_res_r.status == ST_OK || out_res_r.status == ST_CRCBAD))
      |-> out_res_r.dir_valid)
    else $error("pass end without a direction bit");

  a_rom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.status != ST_OK && out_res_r.status != ST_CRCBAD)
      |-> (out_res_r.rom_code == '0))
    else $error("rom code shown outside pass end");

  a_dir_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.dir_valid) |->
      (out_res_r.status == ST_BUSY || out_res_r.status == ST_OK ||
       out_res_r.status == ST_CRCBAD))
    else $error("direction bit with abort status");

  a_end_clears_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_nxt.dir_valid && res_nxt.status != ST_BUSY) |=> !pass_active_r)
    else $error("pass still active after last bit");

endmodule

`default_nettype wire
